// ===== src/lbc_pkg.sv =====
// Package for the line clipper: widths, payload structs, register codes and
// pipeline lengths. Used by every module of the block and by its checker.
package lbc_pkg;

	localparam int COORD_W  = 24;
	localparam int SIZE_W   = COORD_W - 1;
	localparam int PARAM_W  = 16;
	localparam int Q_W      = PARAM_W + 1;
	localparam int DEL_W    = COORD_W + 1;
	localparam int EDGE_W   = COORD_W + 3;
	localparam int DIV_W    = DEL_W;
	localparam int DEN_W    = DIV_W + 1;
	localparam int NUM_W    = DIV_W + Q_W + 1;
	localparam int PROD_W   = Q_W + 1 + DEL_W;
	localparam int EDGES    = 4;
	localparam int DIV_LAT  = Q_W + 1;
	localparam int PIPE_LAT = DIV_LAT + 5;

	localparam logic [Q_W-1:0] PARAM_ONE = Q_W'(1) << PARAM_W;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (PARAM_W - 1);

	typedef enum logic [1:0] {
		CFG_LEFT   = 2'd0,
		CFG_TOP    = 2'd1,
		CFG_WIDTH  = 2'd2,
		CFG_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} seg_in_t;

	typedef struct packed {
		logic                      visible;
		logic signed [COORD_W-1:0] clipped_start_x;
		logic signed [COORD_W-1:0] clipped_start_y;
		logic signed [COORD_W-1:0] clipped_end_x;
		logic signed [COORD_W-1:0] clipped_end_y;
	} seg_out_t;

	typedef struct packed {
		logic [DIV_W-1:0] n;
		logic [DIV_W-1:0] d;
	} div_job_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [DEL_W-1:0]   dx;
		logic signed [DEL_W-1:0]   dy;
		logic                      ok;
		logic [EDGES-1:0]          use_ent;
		logic [EDGES-1:0]          use_ext;
	} side_t;

endpackage

// ===== src/lbc_setup.sv =====
// Front stages of the line clipper: deltas, edge distances and per-edge tests.
// Depends on lbc_pkg.
module lbc_setup import lbc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  seg_in_t                   seg,
	input  logic signed [COORD_W-1:0] left,
	input  logic signed [COORD_W-1:0] top,
	input  logic [SIZE_W-1:0]         width,
	input  logic [SIZE_W-1:0]         height,
	output logic                      out_valid,
	output side_t                     side,
	output div_job_t                  job [EDGES]
);

	logic                      vld_s1;
	logic signed [COORD_W-1:0] ax_s1, ay_s1;
	logic signed [DEL_W-1:0]   dx_s1, dy_s1;
	logic signed [EDGE_W-1:0]  q_s1 [EDGES];
	logic                      vld_s2;
	side_t                     side_s2;
	div_job_t                  job_s2 [EDGES];
	side_t                     side_c;
	div_job_t                  job_c [EDGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1   <= seg.start_x;
		ay_s1   <= seg.start_y;
		dx_s1   <= DEL_W'(seg.end_x) - DEL_W'(seg.start_x);
		dy_s1   <= DEL_W'(seg.end_y) - DEL_W'(seg.start_y);
		q_s1[0] <= EDGE_W'(seg.start_x) - EDGE_W'(left);
		q_s1[1] <= EDGE_W'(left) + $signed({(EDGE_W - SIZE_W)'(0), width})
			- EDGE_W'(seg.start_x);
		q_s1[2] <= EDGE_W'(seg.start_y) - EDGE_W'(top);
		q_s1[3] <= EDGE_W'(top) + $signed({(EDGE_W - SIZE_W)'(0), height})
			- EDGE_W'(seg.start_y);
		side_s2 <= side_c;
		job_s2  <= job_c;
	end

	always_comb begin
		logic signed [EDGE_W-1:0] p;
		logic signed [EDGE_W-1:0] n;
		logic signed [EDGE_W-1:0] d;
		side_c.ax      = ax_s1;
		side_c.ay      = ay_s1;
		side_c.dx      = dx_s1;
		side_c.dy      = dy_s1;
		side_c.ok      = 1'b1;
		side_c.use_ent = '0;
		side_c.use_ext = '0;
		for (int i = 0; i < EDGES; i++) begin
			case (i)
				0:       p = -EDGE_W'(dx_s1);
				1:       p = EDGE_W'(dx_s1);
				2:       p = -EDGE_W'(dy_s1);
				default: p = EDGE_W'(dy_s1);
			endcase
			if (p < 0) begin
				n = -q_s1[i];
				d = -p;
			end else begin
				n = q_s1[i];
				d = p;
			end
			if (p == 0) begin
				if (q_s1[i] < 0)
					side_c.ok = 1'b0;
			end else if (p < 0) begin
				if (n > d)
					side_c.ok = 1'b0;
				else if (n > 0)
					side_c.use_ent[i] = 1'b1;
			end else begin
				if (n < 0)
					side_c.ok = 1'b0;
				else if (n < d)
					side_c.use_ext[i] = 1'b1;
			end
			job_c[i].n = n[DIV_W-1:0];
			job_c[i].d = d[DIV_W-1:0];
		end
	end

	assign out_valid = vld_s2;
	assign side      = side_s2;
	assign job       = job_s2;

endmodule

// ===== src/lbc_div_lane.sv =====
// One edge ratio: restoring division, one quotient bit per pipeline stage,
// giving n/d rounded to nearest in Q1.16. Depends on lbc_pkg.
module lbc_div_lane import lbc_pkg::*; (
	input  logic           clk,
	input  div_job_t       job,
	output logic [Q_W-1:0] quot
);

	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] rem_s [DIV_LAT];
	logic [Q_W-1:0]   low_s [DIV_LAT];
	logic [DEN_W-1:0] den_s [DIV_LAT];
	logic [Q_W-1:0]   quo_s [DIV_LAT];

	assign num = NUM_W'({job.n, Q_W'(0)}) + NUM_W'(job.d);

	always_ff @(posedge clk) begin
		rem_s[0] <= num[NUM_W-1:Q_W];
		low_s[0] <= num[Q_W-1:0];
		den_s[0] <= {job.d, 1'b0};
		quo_s[0] <= '0;
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           fits;
		assign trial = {rem_s[k-1], low_s[k-1][Q_W-1]};
		assign fits  = trial >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			rem_s[k] <= fits ? DEN_W'(trial - {1'b0, den_s[k-1]}) : trial[DEN_W-1:0];
			low_s[k] <= {low_s[k-1][Q_W-2:0], 1'b0};
			den_s[k] <= den_s[k-1];
			quo_s[k] <= {quo_s[k-1][Q_W-2:0], fits};
		end
	end

	assign quot = quo_s[DIV_LAT-1];

endmodule

// ===== src/lbc_interp.sv =====
// Back stages of the line clipper: entry/exit selection, parameter times
// delta, rounding and the result register. Depends on lbc_pkg.
module lbc_interp import lbc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  side_t          side,
	input  logic [Q_W-1:0] quot [EDGES],
	output logic           done,
	output seg_out_t       result
);

	logic                      vld_s1, vld_s2, vld_s3;
	logic                      ok_s1, ok_s2;
	logic [Q_W-1:0]            ent_s1, ext_s1;
	logic signed [COORD_W-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic signed [DEL_W-1:0]   dx_s1, dy_s1;
	logic signed [PROD_W-1:0]  pex_s2, pey_s2, pxx_s2, pxy_s2;
	seg_out_t                  res_s3;
	logic [Q_W-1:0]            ent_c, ext_c;

	always_comb begin
		ent_c = '0;
		ext_c = PARAM_ONE;
		for (int i = 0; i < EDGES; i++) begin
			if (side.use_ent[i] && quot[i] > ent_c)
				ent_c = quot[i];
			if (side.use_ext[i] && quot[i] < ext_c)
				ext_c = quot[i];
		end
	end

	function automatic logic signed [COORD_W-1:0] place(
		input logic signed [COORD_W-1:0] a,
		input logic signed [PROD_W-1:0]  prod
	);
		logic signed [PROD_W-1:0] v;
		v = (prod + $signed(ROUND_HALF)) >>> PARAM_W;
		return COORD_W'(a + v[COORD_W-1:0]);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1  <= side.ok && (ent_c <= ext_c);
		ent_s1 <= ent_c;
		ext_s1 <= ext_c;
		ax_s1  <= side.ax;
		ay_s1  <= side.ay;
		dx_s1  <= side.dx;
		dy_s1  <= side.dy;

		ok_s2  <= ok_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
		pex_s2 <= PROD_W'($signed({1'b0, ent_s1})) * PROD_W'(dx_s1);
		pey_s2 <= PROD_W'($signed({1'b0, ent_s1})) * PROD_W'(dy_s1);
		pxx_s2 <= PROD_W'($signed({1'b0, ext_s1})) * PROD_W'(dx_s1);
		pxy_s2 <= PROD_W'($signed({1'b0, ext_s1})) * PROD_W'(dy_s1);

		if (ok_s2) begin
			res_s3.visible         <= 1'b1;
			res_s3.clipped_start_x <= place(ax_s2, pex_s2);
			res_s3.clipped_start_y <= place(ay_s2, pey_s2);
			res_s3.clipped_end_x   <= place(ax_s2, pxx_s2);
			res_s3.clipped_end_y   <= place(ay_s2, pxy_s2);
		end else begin
			res_s3 <= '0;
		end
	end

	assign done   = vld_s3;
	assign result = res_s3;

endmodule

// ===== src/line_clip_to_rectangle.sv =====
// Line clipper top level: clip rectangle registers, front stages, four
// ratio pipelines and back stages. Depends on lbc_pkg and the lbc modules.
//
// Takes one segment every clock cycle; busy stays low. Each result is on
// done/seg_out for a single cycle, after the front stages, the 18-stage
// quotient pipelines (a load stage, then one quotient bit per stage) that
// form the edge ratios, and the back stages. Results are presented for one
// cycle and cannot be held off.
// Rectangle registers are written through cfg_we/cfg_idx/cfg_wdata and are
// sampled by each segment as it enters.
module line_clip_to_rectangle import lbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  seg_in_t            seg_in,
	output logic               done,
	output seg_out_t           seg_out,
	input  logic               cfg_we,
	input  cfg_idx_t           cfg_idx,
	input  logic [COORD_W-1:0] cfg_wdata
);

	logic signed [COORD_W-1:0] left_q, top_q;
	logic [SIZE_W-1:0]         width_q, height_q;
	logic                      front_vld;
	side_t                     front_side;
	div_job_t                  job [EDGES];
	logic [Q_W-1:0]            quot [EDGES];
	logic                      vld_s [DIV_LAT];
	side_t                     side_s [DIV_LAT];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LEFT:   left_q   <= cfg_wdata;
				CFG_TOP:    top_q    <= cfg_wdata;
				CFG_WIDTH:  width_q  <= cfg_wdata[SIZE_W-1:0];
				CFG_HEIGHT: height_q <= cfg_wdata[SIZE_W-1:0];
				default:    ;
			endcase
		end
	end

	lbc_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.seg       (seg_in),
		.left      (left_q),
		.top       (top_q),
		.width     (width_q),
		.height    (height_q),
		.out_valid (front_vld),
		.side      (front_side),
		.job       (job)
	);

	for (genvar e = 0; e < EDGES; e++) begin : g_lane
		lbc_div_lane u_lane (
			.clk  (clk),
			.job  (job[e]),
			.quot (quot[e])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++)
				vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= front_vld;
			for (int k = 1; k < DIV_LAT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= front_side;
		for (int k = 1; k < DIV_LAT; k++)
			side_s[k] <= side_s[k-1];
	end

	lbc_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s[DIV_LAT-1]),
		.side     (side_s[DIV_LAT-1]),
		.quot     (quot),
		.done     (done),
		.result   (seg_out)
	);

endmodule

// ===== src/lbc_checker.sv =====
// Port-level checks for the line clipper, bound to the top level.
// Depends on lbc_pkg.
module lbc_checker import lbc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input seg_out_t seg_out
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("transaction result missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without transaction");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !seg_out.visible) |-> (seg_out.clipped_start_x == '0
			&& seg_out.clipped_start_y == '0 && seg_out.clipped_end_x == '0
			&& seg_out.clipped_end_y == '0))
		else $error("rejected segment carries coordinates");

endmodule

bind line_clip_to_rectangle lbc_checker u_lbc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.seg_out (seg_out)
);

// ===== test/line_clip_to_rectangle_test.sv =====
// Self-checking bench for line_clip_to_rectangle: random and corner segments,
// predicted results checked in order. Depends on lbc_pkg and the block's RTL.
module line_clip_to_rectangle_test;
	import lbc_pkg::*;

	localparam longint ONE_Q = longint'(1) << PARAM_W;
	localparam int LATENCY = PIPE_LAT + 8;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	seg_in_t seg_in = '0;
	logic done;
	seg_out_t seg_out;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_idx = CFG_LEFT;
	logic [COORD_W-1:0] cfg_wdata = '0;

	seg_in_t segments_pending[$];
	seg_out_t clips_expected[$];
	longint rect_left, rect_top, rect_w, rect_h;
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	line_clip_to_rectangle dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	function automatic longint quot_round(longint n, longint d);
		longint r;
		r = (2 * n * ONE_Q + d) / (2 * d);
		return (r > ONE_Q) ? ONE_Q : r;
	endfunction

	function automatic logic [COORD_W-1:0] point_on(longint a, longint d, longint t);
		longint v;
		v = t * d + (ONE_Q >> 1);
		v = (v >= 0) ? (v / ONE_Q) : -((-v + ONE_Q - 1) / ONE_Q);
		return COORD_W'(a + v);
	endfunction

	function automatic seg_out_t clip_segment(seg_in_t s);
		longint ax, ay, dx, dy, n, d, r, t_in, t_out;
		longint p[4], q[4];
		bit ok;
		seg_out_t o;
		ax = longint'(s.start_x);
		ay = longint'(s.start_y);
		dx = longint'(s.end_x) - ax;
		dy = longint'(s.end_y) - ay;
		p[0] = -dx; q[0] = ax - rect_left;
		p[1] = dx;  q[1] = rect_left + rect_w - ax;
		p[2] = -dy; q[2] = ay - rect_top;
		p[3] = dy;  q[3] = rect_top + rect_h - ay;
		t_in = 0;
		t_out = ONE_Q;
		ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (p[i] == 0) begin
				if (q[i] < 0) ok = 1'b0;
			end else if (p[i] < 0) begin
				n = -q[i]; d = -p[i];
				if (n > d) ok = 1'b0;
				else if (n > 0) begin
					r = quot_round(n, d);
					if (r > t_in) t_in = r;
				end
			end else begin
				n = q[i]; d = p[i];
				if (n < 0) ok = 1'b0;
				else if (n < d) begin
					r = quot_round(n, d);
					if (r < t_out) t_out = r;
				end
			end
		end
		if (t_in > t_out) ok = 1'b0;
		o = '0;
		if (ok) begin
			o.visible = 1'b1;
			o.clipped_start_x = point_on(ax, dx, t_in);
			o.clipped_start_y = point_on(ay, dy, t_in);
			o.clipped_end_x = point_on(ax, dx, t_out);
			o.clipped_end_y = point_on(ay, dy, t_out);
		end
		return o;
	endfunction

	// driver
	always @(negedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && !cfg_we && segments_pending.size() > 0
				&& (quiet || $urandom_range(99) >= 16)) begin
			seg_in <= segments_pending[0];
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: accept transactions, predict and check
	always @(posedge clk) begin
		if (start && !busy) begin
			clips_expected = {clips_expected, clip_segment(seg_in)};
			void'(segments_pending.pop_front());
		end
		if (done) begin
			if (clips_expected.size() == 0) begin
				report("result with nothing expected");
			end else begin
				seg_out_t e;
				e = clips_expected.pop_front();
				if (seg_out.visible !== e.visible)
					report($sformatf("visible %b exp %b", seg_out.visible, e.visible));
				if (seg_out.clipped_start_x !== e.clipped_start_x)
					report($sformatf("start_x %h exp %h", seg_out.clipped_start_x,
						e.clipped_start_x));
				if (seg_out.clipped_start_y !== e.clipped_start_y)
					report($sformatf("start_y %h exp %h", seg_out.clipped_start_y,
						e.clipped_start_y));
				if (seg_out.clipped_end_x !== e.clipped_end_x)
					report($sformatf("end_x %h exp %h", seg_out.clipped_end_x,
						e.clipped_end_x));
				if (seg_out.clipped_end_y !== e.clipped_end_y)
					report($sformatf("end_y %h exp %h", seg_out.clipped_end_y,
						e.clipped_end_y));
			end
		end
	end

	task automatic drain();
		while (segments_pending.size() > 0 || clips_expected.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, longint value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= COORD_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LEFT:   rect_left = longint'($signed(COORD_W'(value)));
			CFG_TOP:    rect_top = longint'($signed(COORD_W'(value)));
			CFG_WIDTH:  rect_w = value & ((longint'(1) << SIZE_W) - 1);
			default:    rect_h = value & ((longint'(1) << SIZE_W) - 1);
		endcase
	endtask

	task automatic set_rect(longint l, longint t, longint w, longint h);
		write_reg(CFG_LEFT, l);
		write_reg(CFG_TOP, t);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
	endtask

	task automatic add_seg(longint ax, longint ay, longint bx, longint by);
		seg_in_t s;
		s.start_x = COORD_W'(ax);
		s.start_y = COORD_W'(ay);
		s.end_x = COORD_W'(bx);
		s.end_y = COORD_W'(by);
		segments_pending = {segments_pending, s};
	endtask

	function automatic longint near_rect(bit horiz);
		longint base, span;
		base = horiz ? rect_left : rect_top;
		span = horiz ? rect_w : rect_h;
		case ($urandom_range(3))
			0: return longint'($signed(COORD_W'($urandom)));
			1: return base + $urandom_range(0, 2 * int'(span > 1000000 ? 1000000 : span))
				- int'(span > 1000000 ? 1000000 : span) / 2;
			2: return base + ($urandom_range(1) ? span : 0) + $urandom_range(4) - 2;
			default: return base + $urandom_range(0, int'(span > 1000000 ? 1000000 : span));
		endcase
	endfunction

	task automatic random_block(int count);
		longint ax, ay;
		for (int i = 0; i < count; i++) begin
			ax = near_rect(1'b1);
			ay = near_rect(1'b0);
			case ($urandom_range(5))
				0: add_seg(ax, ay, ax, near_rect(1'b0));
				1: add_seg(ax, ay, near_rect(1'b1), ay);
				2: add_seg(ax, ay, ax, ay);
				default: add_seg(ax, ay, near_rect(1'b1), near_rect(1'b0));
			endcase
		end
	endtask

	localparam longint CMIN = -(longint'(1) << (COORD_W - 1));
	localparam longint CMAX = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint SMAX = (longint'(1) << SIZE_W) - 1;

	initial begin
		rect_left = 0; rect_top = 0; rect_w = 0; rect_h = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset rectangle is a single point at origin
		add_seg(0, 0, 0, 0);
		add_seg(-256, 0, 256, 0);
		add_seg(1, 1, 1, 1);
		drain();

		set_rect(-2560, -1280, 5120, 2560);
		add_seg(CMIN, CMIN, CMAX, CMAX);
		add_seg(CMAX, CMAX, CMIN, CMIN);
		add_seg(CMIN, 0, CMAX, 0);
		add_seg(0, CMAX, 0, CMIN);
		add_seg(-5000, 0, -3000, 0);
		add_seg(0, 5000, 0, 4000);
		add_seg(-2560, -1280, 2560, 1280);
		add_seg(-2560, 2000, -2560, -2000);
		add_seg(-3000, -3000, -3000, 3000);
		add_seg(0, 0, 100, 50);
		add_seg(-10000, 1500, 10000, 1400);
		add_seg(-4000, 0, 0, -4000);
		add_seg(2560, 1280, 2560, 1280);
		add_seg(2561, 0, 2561, 0);
		add_seg(-1, -1, 1, 1);
		add_seg(CMAX, CMIN, CMIN, CMAX);
		drain();

		set_rect(CMIN, CMIN, SMAX, SMAX);
		add_seg(CMIN, CMIN, CMAX, CMAX);
		add_seg(CMAX, CMAX, CMAX, CMAX);
		add_seg(CMAX, 0, CMIN, 0);
		random_block(60);
		drain();

		set_rect(CMAX, CMAX, 0, 0);
		random_block(40);
		add_seg(CMAX, CMAX, CMAX, CMAX);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			set_rect(longint'($signed(COORD_W'($urandom))),
				longint'($signed(COORD_W'($urandom))),
				(ph == 3) ? SMAX : $urandom_range(0, 1 << (8 + 4 * ph)),
				(ph == 0) ? 0 : $urandom_range(0, 1 << (8 + 4 * ph)));
			quiet = (ph == 1);
			random_block(200);
			drain();
		end
		quiet = 1'b0;
		set_rect(0, 0, SMAX, SMAX);
		random_block(40);
		drain();

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
